### rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// shared constants, codes and helpers of the table interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_MAX_COLUMNS = 16;
	localparam int RESULT_LIMIT    = 16;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_ROWS_IN_USE    = 2'd0,
		REG_COLUMNS_IN_USE = 2'd1
	} reg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_K0,
		ST_RD_KL,
		ST_CHK,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_PREP,
		ST_PREP2,
		ST_EMIT,
		ST_RD_Y1,
		ST_RD_Y2,
		ST_DIFF,
		ST_MAG,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	function automatic logic [31:0] mag33(logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

endpackage

### rtl/tli_ifs.sv
// ----------------------------------------------------------------------------
// tli_ifs
// item channels and configuration write channel
// ----------------------------------------------------------------------------
interface tli_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [5:0]         row;
	logic [3:0]         column;
	logic signed [31:0] entry_value;
	logic signed [31:0] x_value;
	modport source (output valid, mode, row, column, entry_value, x_value, input ready);
	modport sink   (input valid, mode, row, column, entry_value, x_value, output ready);
endinterface

interface tli_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_column;
	logic signed [31:0] out_value;
	logic               last;
	logic               extrapolated;
	logic               divide_fault;
	modport source (output valid, out_column, out_value, last, extrapolated, divide_fault,
		input ready);
	modport sink   (input valid, out_column, out_value, last, extrapolated, divide_fault,
		output ready);
endinterface

interface tli_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [31:0] wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/tli_ram.sv
// ----------------------------------------------------------------------------
// tli_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/tli_div.sv
// ----------------------------------------------------------------------------
// tli_div
// restoring divider, 64 by 32 bits unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tli_div
	import tli_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl_in,
	output div_ctl_t    ctl_out,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] div_q;
	logic [32:0] sh;
	logic        ge;
	logic [32:0] diff;

	assign sh   = {rem_q, quo_q[63]};
	assign ge   = sh >= {1'b0, div_q};
	assign diff = sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign ctl_out.start = busy_q;
	assign ctl_out.done  = done_q;
	assign quotient      = quo_q;

endmodule

### rtl/table_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit
// piecewise linear lookup over a q16.16 table with an ascending key column
// ----------------------------------------------------------------------------
// in_ch carries items: mode 0 writes entry_value at (row, column), mode 1
// queries with x_value. cfg writes rows_in_use (index 0) and columns_in_use
// (index 1); it is always ready. out_ch gives one item per column in use,
// column 0 first, last set on the final one.
// A write item is stored and gives nothing. A query reads the first and
// last keys, scans keys row by row when x lies between them, then gives
// column 0 and goes column by column: an exact key match or a divide fault
// takes each column straight from the table, while an interpolated or
// extrapolated column waits for the shared 64-step restoring divider. in_ch
// is ready only between queries.
// out_ch has one output register; when the receiver stalls the sequencer
// holds its next item and waits. Reset clears control state and sets both
// registers to 2; table contents are undefined until written.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit
	import tli_pkg::*;
#(
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
	input logic       clk,
	input logic       arst_n,
	tli_in_if.sink    in_ch,
	tli_out_if.source out_ch,
	tli_cfg_if.sink   cfg
);

	localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
	localparam int AW      = $clog2(DEPTH);
	localparam int RIW     = $clog2(MAX_ROWS);
	localparam int COL_LIM = (MAX_COLUMNS < RESULT_LIMIT) ? MAX_COLUMNS : RESULT_LIMIT;

	state_t state_q, state_d;

	logic [6:0]  rows_q;
	logic [4:0]  cols_q;

	logic [RIW-1:0] last_row, lastr_q, r_q, r1_q, r2_q;
	logic [3:0]     last_col, lastc_q, c_q;

	logic signed [31:0] x_q, k0_q, k1_q, k2_q, prevk_q, y1_q;
	logic signed [32:0] dk_q, dx_q, dy_q;
	logic [31:0]        dkm_q, dxm_q, dym_q;
	logic               neg_q, match_q, outside_q, fault_q;
	logic [63:0]        prod_q, quo;
	logic signed [31:0] val_q;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [RIW-1:0]     rd_row;
	logic [3:0]         rd_col;
	logic [31:0]        rdata;
	logic signed [31:0] rkey;
	logic               in_acc, out_free, out_load;
	div_ctl_t           div_in, div_out;
	logic signed [42:0] sum;
	logic               q_big;

	logic               ov_q;
	logic [3:0]         oc_q;
	logic signed [31:0] ovl_q;
	logic               ol_q, oe_q, of_q;

	assign rkey     = signed'(rdata);
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !ov_q || out_ch.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		if (rows_q < 7'd2) begin
			last_row = RIW'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			last_row = RIW'(MAX_ROWS - 1);
		end else begin
			last_row = RIW'(rows_q - 7'd1);
		end
		if (cols_q < 5'd2) begin
			last_col = 4'd1;
		end else if (32'(cols_q) > 32'(COL_LIM)) begin
			last_col = 4'(COL_LIM - 1);
		end else begin
			last_col = 4'(cols_q - 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd2;
			cols_q <= 5'd2;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.reg_index)
				REG_ROWS_IN_USE:    rows_q <= cfg.wr_data[6:0];
				REG_COLUMNS_IN_USE: cols_q <= cfg.wr_data[4:0];
				default: ;
			endcase
		end
	end

	// table store
	assign we    = in_acc && (in_ch.mode == MODE_WRITE) && (32'(in_ch.row) < 32'(MAX_ROWS))
		&& (32'(in_ch.column) < 32'(MAX_COLUMNS));
	assign waddr = AW'(32'(in_ch.row) * 32'(MAX_COLUMNS) + 32'(in_ch.column));
	assign raddr = AW'(32'(rd_row) * 32'(MAX_COLUMNS) + 32'(rd_col));

	tli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_ch.entry_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	tli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (div_in),
		.ctl_out  (div_out),
		.dividend (prod_q),
		.divisor  (dkm_q),
		.quotient (quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_acc && in_ch.mode == MODE_QUERY) state_d = ST_RD_K0;
			ST_RD_K0:    state_d = ST_RD_KL;
			ST_RD_KL:    state_d = ST_CHK;
			ST_CHK: begin
				if (x_q >= k0_q && x_q <= rkey) state_d = ST_SCAN_RD;
				else state_d = ST_PREP;
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (x_q == rkey || (x_q < rkey && r_q != '0)) state_d = ST_PREP;
				else state_d = ST_SCAN_RD;
			end
			ST_PREP:     state_d = ST_PREP2;
			ST_PREP2:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = (c_q == lastc_q) ? ST_IDLE : ST_RD_Y1;
			end
			ST_RD_Y1:    state_d = ST_RD_Y2;
			ST_RD_Y2:    state_d = ST_DIFF;
			ST_DIFF:     state_d = (match_q || fault_q) ? ST_EMIT : ST_MAG;
			ST_MAG:      state_d = ST_MUL;
			ST_MUL:      state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_out.done) state_d = ST_SUM;
			ST_SUM:      state_d = ST_EMIT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		div_in.start = (state_q == ST_DIV_GO);
		div_in.done  = 1'b0;
		out_load     = (state_q == ST_EMIT) && out_free;
		rd_col       = c_q;
		case (state_q)
			ST_RD_K0:   begin rd_row = '0;      rd_col = '0; end
			ST_RD_KL:   begin rd_row = lastr_q; rd_col = '0; end
			ST_SCAN_RD: begin rd_row = r_q;     rd_col = '0; end
			ST_RD_Y1:   rd_row = r1_q;
			ST_RD_Y2:   rd_row = r2_q;
			default:    rd_row = r_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign q_big = (quo[63:41] != '0) || (quo[40] && quo[39:0] != '0);
	assign sum   = neg_q ? (43'(y1_q) - signed'({2'b00, quo[40:0]}))
		: (43'(y1_q) + signed'({2'b00, quo[40:0]}));

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q       <= in_ch.x_value;
				lastr_q   <= last_row;
				lastc_q   <= last_col;
				match_q   <= 1'b0;
				outside_q <= 1'b0;
				r_q       <= '0;
			end
			ST_RD_KL: k0_q <= rkey;
			ST_CHK: begin
				if (!(x_q >= k0_q && x_q <= rkey)) begin
					outside_q <= 1'b1;
					r1_q      <= '0;
					r2_q      <= lastr_q;
					k1_q      <= k0_q;
					k2_q      <= rkey;
				end
			end
			ST_SCAN_CMP: begin
				if (x_q == rkey) begin
					match_q <= 1'b1;
					r1_q    <= r_q;
					r2_q    <= r_q;
					k1_q    <= rkey;
					k2_q    <= rkey;
				end else if (x_q < rkey && r_q != '0) begin
					r1_q <= r_q - RIW'(1);
					r2_q <= r_q;
					k1_q <= prevk_q;
					k2_q <= rkey;
				end else begin
					prevk_q <= rkey;
					r_q     <= r_q + RIW'(1);
				end
			end
			ST_PREP: begin
				dk_q <= 33'(k2_q) - 33'(k1_q);
				dx_q <= 33'(x_q) - 33'(k1_q);
			end
			ST_PREP2: begin
				fault_q <= !match_q && (dk_q == '0);
				dkm_q   <= mag33(dk_q);
				dxm_q   <= mag33(dx_q);
				c_q     <= '0;
				val_q   <= x_q;
			end
			ST_EMIT: if (out_free) c_q <= c_q + 4'd1;
			ST_RD_Y2: y1_q <= rkey;
			ST_DIFF: begin
				val_q <= y1_q;
				dy_q  <= 33'(rkey) - 33'(y1_q);
			end
			ST_MAG: begin
				dym_q <= mag33(dy_q);
				neg_q <= dy_q[32] ^ dx_q[32] ^ dk_q[32];
			end
			ST_MUL: prod_q <= 64'(dym_q) * 64'(dxm_q);
			ST_SUM: begin
				if (q_big) begin
					val_q <= neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
				end else if (sum > 43'sd2147483647) begin
					val_q <= 32'sh7fff_ffff;
				end else if (sum < -43'sd2147483648) begin
					val_q <= 32'sh8000_0000;
				end else begin
					val_q <= sum[31:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oc_q  <= c_q;
			ovl_q <= val_q;
			ol_q  <= (c_q == lastc_q);
			oe_q  <= outside_q;
			of_q  <= fault_q;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.out_column   = oc_q;
	assign out_ch.out_value    = ovl_q;
	assign out_ch.last         = ol_q;
	assign out_ch.extrapolated = oe_q;
	assign out_ch.divide_fault = of_q;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of table_linear_interpolator_unit
// ----------------------------------------------------------------------------
// Fills the key and first value column of every row and all columns of the
// first few rows, then runs directed and random query phases over several
// row and column settings; wide settings stay within those first rows.
// Each accepted query is predicted in 64-bit arithmetic; every result item
// is checked in order against the expected column values and flags. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import tli_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDE_ROWS = 4;

	typedef struct {
		logic [3:0]  column;
		logic [31:0] value;
		logic        last;
		logic        extrapolated;
		logic        divide_fault;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	tli_in_if  in_ch();
	tli_out_if out_ch();
	tli_cfg_if cfg();

	table_linear_interpolator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	logic signed [31:0] table_copy [DEF_MAX_ROWS][DEF_MAX_COLUMNS];
	logic [6:0]         rows_reg;
	logic [4:0]         cols_reg;
	lookup_result_t     pending_results[$];
	int                 fail_count;
	int                 query_count;
	int                 write_count;
	int                 result_count;
	int                 fault_count;
	int                 outside_count;
	bit                 send_gaps;
	bit                 recv_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("table_linear_interpolator_unit verification failed");
		$finish;
	end

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint line_point(longint k1, longint k2, longint y1, longint y2,
			longint x, ref bit fault);
		longint dk, dy, dx, r;
		longint unsigned q;
		bit neg;
		dk = k2 - k1;
		dy = y2 - y1;
		dx = x - k1;
		if (dk == 0) begin
			fault = 1'b1;
			return y1;
		end
		neg = ((dy < 0) != (dx < 0)) != (dk < 0);
		q = (magnitude(dy) * magnitude(dx)) / magnitude(dk);
		if (q > 64'h100_0000_0000)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		r = neg ? y1 - longint'(q) : y1 + longint'(q);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	function automatic longint entry(int r, int c);
		return longint'(table_copy[r][c]);
	endfunction

	function automatic void predict_lookup(logic signed [31:0] x_in);
		int rows, cols, lastr;
		longint x;
		longint vals [RESULT_LIMIT];
		bit outside, fault, done;
		lookup_result_t res;
		rows = rows_reg < 2 ? 2 : (rows_reg > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_reg);
		cols = cols_reg < 2 ? 2 : (cols_reg > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : cols_reg);
		x = longint'(x_in);
		lastr = rows - 1;
		vals[0] = x;
		outside = 1'b0;
		fault = 1'b0;
		done = 1'b0;
		if (x >= entry(0, 0) && x <= entry(lastr, 0)) begin
			for (int r = 0; r < rows && !done; r++) begin
				if (x == entry(r, 0)) begin
					for (int c = 1; c < cols; c++) vals[c] = entry(r, c);
					done = 1'b1;
				end else if (x < entry(r, 0) && r > 0) begin
					for (int c = 1; c < cols; c++)
						vals[c] = line_point(entry(r - 1, 0), entry(r, 0), entry(r - 1, c),
							entry(r, c), x, fault);
					done = 1'b1;
				end
			end
		end
		if (!done) begin
			outside = 1'b1;
			for (int c = 1; c < cols; c++)
				vals[c] = line_point(entry(0, 0), entry(lastr, 0), entry(0, c),
					entry(lastr, c), x, fault);
		end
		if (outside) outside_count++;
		if (fault) fault_count++;
		for (int c = 0; c < cols; c++) begin
			res.column = c[3:0];
			res.value = vals[c][31:0];
			res.last = (c + 1 == cols);
			res.extrapolated = outside;
			res.divide_fault = fault;
			pending_results.push_back(res);
		end
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
		return $urandom_range(8, 40);
	endfunction

	// result checker
	always @(posedge clk) begin
		lookup_result_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: column %0d value %0d",
					out_ch.out_column, out_ch.out_value);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_ch.out_column !== exp_r.column) begin
					$error("out_column: expected %0d, actual %0d", exp_r.column,
						out_ch.out_column);
					fail_count++;
				end
				if (out_ch.out_value !== exp_r.value) begin
					$error("out_value: expected %0d, actual %0d", $signed(exp_r.value),
						out_ch.out_value);
					fail_count++;
				end
				if (out_ch.last !== exp_r.last) begin
					$error("last: expected %0b, actual %0b", exp_r.last, out_ch.last);
					fail_count++;
				end
				if (out_ch.extrapolated !== exp_r.extrapolated) begin
					$error("extrapolated: expected %0b, actual %0b", exp_r.extrapolated,
						out_ch.extrapolated);
					fail_count++;
				end
				if (out_ch.divide_fault !== exp_r.divide_fault) begin
					$error("divide_fault: expected %0b, actual %0b", exp_r.divide_fault,
						out_ch.divide_fault);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (recv_stalls) begin
				out_ch.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	task automatic send_item(logic mode, logic [5:0] row, logic [3:0] column,
			logic signed [31:0] value, logic signed [31:0] x);
		int gap;
		gap = send_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.row <= row;
		in_ch.column <= column;
		in_ch.entry_value <= value;
		in_ch.x_value <= x;
		do @(posedge clk); while (!in_ch.ready);
		if (mode == MODE_WRITE) begin
			table_copy[row][column] = value;
			write_count++;
		end else begin
			predict_lookup(x);
			query_count++;
		end
	endtask

	task automatic write_entry(int r, int c, logic signed [31:0] v);
		send_item(MODE_WRITE, r[5:0], c[3:0], v, $urandom);
	endtask

	task automatic lookup(logic signed [31:0] x);
		send_item(MODE_QUERY, 6'($urandom), 4'($urandom), $urandom, x);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_register(reg_index_t idx, logic [31:0] data);
		drain();
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wr_data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_ROWS_IN_USE) rows_reg = data[6:0];
		else cols_reg = data[4:0];
	endtask

	// ascending keys for the first rows, with an occasional repeated key when with_repeats is set
	task automatic load_keys(int rows, bit with_repeats);
		longint k, step_max;
		k = -64'sd2147483648 + $urandom_range(0, 32'h3fff_ffff);
		step_max = (64'sd2147483647 - k) / rows;
		if (step_max > 32'hffff_ffff) step_max = 32'hffff_ffff;
		for (int r = 0; r < rows; r++) begin
			write_entry(r, 0, k[31:0]);
			if (!(with_repeats && $urandom_range(0, 5) == 0))
				k += $urandom_range(1, int'(step_max));
		end
	endtask

	task automatic test_fill_table();
		send_gaps = 1'b0;
		load_keys(DEF_MAX_ROWS, 1'b0);
		for (int r = 0; r < DEF_MAX_ROWS; r++)
			write_entry(r, 1, $urandom);
		for (int r = 0; r < WIDE_ROWS; r++)
			for (int c = 2; c < DEF_MAX_COLUMNS; c++)
				write_entry(r, c, $urandom);
		send_gaps = 1'b1;
	endtask

	task automatic test_reset_defaults();
		write_entry(0, 0, 32'sh0001_0000);
		write_entry(1, 0, 32'sh0005_0000);
		write_entry(0, 1, 32'sh8000_0000);
		write_entry(1, 1, 32'sh7fff_ffff);
		lookup(32'sh0001_0000);
		lookup(32'sh0005_0000);
		lookup(32'sh0003_8000);
		lookup(32'sh8000_0000);
		lookup(32'sh7fff_ffff);
		lookup(32'sh0000_0000);
		// repeated key gives a divide fault, except on an exact match
		write_entry(1, 0, 32'sh0001_0000);
		lookup(32'sh0001_0000);
		lookup(32'sh0002_0000);
		lookup(32'shffff_0000);
		// tiny key span with a large value swing overflows the sum
		write_entry(0, 0, 32'sh0000_0000);
		write_entry(1, 0, 32'sh0000_0001);
		lookup(32'sh7fff_ffff);
		lookup(32'sh8000_0000);
		write_entry(0, 1, 32'sh0000_0000);
		write_entry(1, 1, 32'sh0000_0000);
		lookup(32'sh1234_5678);
	endtask

	task automatic test_register_limits();
		write_register(REG_ROWS_IN_USE, 32'h0);
		write_register(REG_COLUMNS_IN_USE, 32'h1);
		lookup($urandom);
		write_register(REG_ROWS_IN_USE, 32'hffff_ff7f);
		lookup(table_copy[DEF_MAX_ROWS - 1][0]);
		lookup(table_copy[0][0]);
		lookup(32'h7fff_ffff);
		write_register(REG_ROWS_IN_USE, WIDE_ROWS);
		write_register(REG_COLUMNS_IN_USE, 32'hffff_ff1f);
		lookup(table_copy[1][0]);
		lookup($urandom);
		write_register(REG_COLUMNS_IN_USE, 32'd17);
		lookup($urandom);
	endtask

	task automatic random_phase(int rows, int cols, int queries, bit reload, bit repeats);
		int kind, r;
		longint lo, hi;
		write_register(REG_ROWS_IN_USE, rows);
		write_register(REG_COLUMNS_IN_USE, cols);
		if (reload) load_keys(rows, repeats);
		for (int i = 0; i < queries; i++) begin
			kind = $urandom_range(0, 19);
			r = $urandom_range(0, rows - 1);
			if (kind < 5) begin
				lookup(table_copy[r][0]);
			end else if (kind < 12 && r > 0) begin
				lo = entry(r - 1, 0);
				hi = entry(r, 0);
				lookup(32'(lo + ((hi - lo) * $urandom_range(0, 1000)) / 1000));
			end else if (kind < 16) begin
				lookup($urandom);
			end else if (kind < 18) begin
				write_entry(r, $urandom_range(1, cols - 1), $urandom);
			end else begin
				// noise: any entry of the store, keys included
				write_entry($urandom_range(0, 63), $urandom_range(0, 15), $urandom);
			end
		end
	endtask

	task automatic test_random_settings();
		random_phase(2, 2, 30, 1'b1, 1'b1);
		random_phase(64, 2, 30, 1'b0, 1'b0);
		random_phase(WIDE_ROWS, 16, 20, 1'b1, 1'b0);
		recv_stalls = 1'b0;
		send_gaps = 1'b0;
		random_phase(WIDE_ROWS, 4, 25, 1'b1, 1'b1);
		recv_stalls = 1'b1;
		send_gaps = 1'b1;
		for (int p = 0; p < 2; p++)
			random_phase($urandom_range(2, 64), 2, 20, 1'b0, 1'b0);
	endtask

	initial begin
		fail_count = 0;
		query_count = 0;
		write_count = 0;
		result_count = 0;
		fault_count = 0;
		outside_count = 0;
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		rows_reg = 7'd2;
		cols_reg = 5'd2;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_WRITE;
		in_ch.row = '0;
		in_ch.column = '0;
		in_ch.entry_value = '0;
		in_ch.x_value = '0;
		cfg.valid = 1'b0;
		cfg.reg_index = REG_ROWS_IN_USE;
		cfg.wr_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_table();
		test_reset_defaults();
		test_register_limits();
		test_random_settings();
		drain();

		$display("covered %0d queries and %0d table writes, %0d result items checked",
			query_count, write_count, result_count);
		$display("queries outside the key range: %0d, with a divide fault: %0d",
			outside_count, fault_count);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("table_linear_interpolator_unit verification clean");
		end else begin
			$display("table_linear_interpolator_unit verification failed");
		end
		$finish;
	end

endmodule
